[rtl/assert_macros.svh]
// assertion macros shared by the watchdog rtl
// depends on nothing; each use names its own clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_IMPL(lbl, clk, rst_n, !(cond), msg)

`endif

[rtl/mtcw_pkg.sv]
// types and mode codes for the multi-task check-in watchdog
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtcw_pkg;

  localparam int unsigned MASK_W = 16;

  localparam logic [1:0] MODE_SCAN        = 2'd0;
  localparam logic [1:0] MODE_REGISTER    = 2'd1;
  localparam logic [1:0] MODE_SET_TIMEOUT = 2'd2;
  localparam logic [1:0] MODE_CHECKIN     = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  task_index;
    logic [31:0] now_ms;
    logic [31:0] timeout_value;
  } mtcw_in_t;

  typedef struct packed {
    logic              status;
    logic [MASK_W-1:0] withheld_mask;
    logic [MASK_W-1:0] newly_withheld;
    logic              any_withheld;
  } mtcw_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic load;
  } mtcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } mtcw_stat_t;

endpackage

`default_nettype wire

[rtl/mtcw_ctrl.sv]
// sequencer for the watchdog: accepts transactions, walks the slot table on a scan
// depends on mtcw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtcw_ctrl import mtcw_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned SLOT_W    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_mode,
  output logic                   in_stall,
  output mtcw_cmd_t              cmd,
  output logic [SLOT_W-1:0]      rd_addr,
  input  mtcw_stat_t             stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic              in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          ptr_nxt   = '0;
          state_nxt = (in_mode == MODE_SCAN) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        ptr_nxt     = ptr_r + 1'b1;
        if (ptr_r == LAST_SLOT) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read is evaluated here
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = stat.out_free;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ptr_r      <= '0;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;
  assign rd_addr  = ptr_r;

  `ASSERT_IMPL(a_scan_starts, clk, rst_n,
               in_valid && !in_stall && in_mode == MODE_SCAN |=> state_r == ST_SCAN,
               "scan transaction did not start a table walk")
  `ASSERT_IMPL(a_scan_moves_on, clk, rst_n,
               state_r == ST_SCAN |=> state_r == ST_SCAN || state_r == ST_DRAIN,
               "table walk left early")
  `ASSERT_IMPL(a_load_frees_input, clk, rst_n,
               cmd.load |=> !in_stall,
               "input still stalled after result load")

endmodule

`default_nettype wire

[rtl/mtcw_dp.sv]
// slot table, scan compare and result register of the watchdog
// depends on mtcw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtcw_dp import mtcw_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned SLOT_W    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  mtcw_in_t               in_data,
  input  mtcw_cmd_t              cmd,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output mtcw_stat_t             stat,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mtcw_out_t              out_data
);

  logic [31:0]          timeout_mem [NUM_SLOTS];
  logic [31:0]          checkin_mem [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] valid_r;
  logic [NUM_SLOTS-1:0] withheld_r;
  logic [NUM_SLOTS-1:0] fresh_r;
  logic [31:0]          now_r;
  logic                 status_r;
  logic [31:0]          tmo_rd_r;
  logic [31:0]          last_rd_r;
  logic [SLOT_W-1:0]    rd_idx_r;
  logic                 rd_vld_r;
  logic                 out_valid_r;
  mtcw_out_t            out_data_r;

  logic [SLOT_W+3:0]    idx_wide;
  logic [SLOT_W-1:0]    wr_addr;
  logic                 in_range;
  logic                 slot_ok;
  logic [31:0]          elapsed;
  logic                 overdue;
  logic [NUM_SLOTS+MASK_W-1:0] withheld_ext;
  logic [NUM_SLOTS+MASK_W-1:0] fresh_ext;

  assign idx_wide = {SLOT_W'(0), in_data.task_index};
  assign wr_addr  = idx_wide[SLOT_W-1:0];
  assign in_range = ({28'd0, in_data.task_index} < 32'(NUM_SLOTS));
  assign slot_ok  = in_range && valid_r[wr_addr];

  // wrapping age against the slot timeout
  assign elapsed  = now_r - last_rd_r;
  assign overdue  = valid_r[rd_idx_r] && !withheld_r[rd_idx_r] && (elapsed > tmo_rd_r);

  // slot table memories, single write and single registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && in_range) begin
      if (in_data.mode == MODE_REGISTER ||
          (in_data.mode == MODE_SET_TIMEOUT && valid_r[wr_addr])) begin
        timeout_mem[wr_addr] <= in_data.timeout_value;
      end
      if (in_data.mode == MODE_REGISTER ||
          (in_data.mode == MODE_CHECKIN && valid_r[wr_addr])) begin
        checkin_mem[wr_addr] <= in_data.now_ms;
      end
    end
    if (cmd.scan_rd) begin
      tmo_rd_r  <= timeout_mem[rd_addr];
      last_rd_r <= checkin_mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      withheld_r <= '0;
      fresh_r    <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.accept) begin
        fresh_r <= '0;
        if (in_range && in_data.mode == MODE_REGISTER) begin
          valid_r[wr_addr]    <= 1'b1;
          withheld_r[wr_addr] <= 1'b0;
        end else if (slot_ok && in_data.mode == MODE_CHECKIN) begin
          withheld_r[wr_addr] <= 1'b0;
        end
      end else if (rd_vld_r && overdue) begin
        withheld_r[rd_idx_r] <= 1'b1;
        fresh_r[rd_idx_r]    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r <= in_data.now_ms;
      if (in_data.mode == MODE_SCAN || (in_range && in_data.mode == MODE_REGISTER)) begin
        status_r <= 1'b0;
      end else begin
        status_r <= !slot_ok;
      end
    end
  end

  // masks cover slots 0 to 15 only
  assign withheld_ext = {MASK_W'(0), withheld_r};
  assign fresh_ext    = {MASK_W'(0), fresh_r};

  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.status         <= status_r;
      out_data_r.withheld_mask  <= withheld_ext[MASK_W-1:0];
      out_data_r.newly_withheld <= fresh_ext[MASK_W-1:0];
      out_data_r.any_withheld   <= |withheld_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_load_overwrite, clk, rst_n,
                cmd.load && out_valid_r && out_stall,
                "result register overwritten while stalled")
  `ASSERT_IMPL(a_fresh_subset, clk, rst_n,
               (fresh_r & ~withheld_r) == '0,
               "newly withheld slot is not withheld")
  `ASSERT_IMPL(a_withheld_valid, clk, rst_n,
               (withheld_r & ~valid_r) == '0,
               "withheld flag on unregistered slot")

endmodule

`default_nettype wire

[rtl/multi_task_checkin_watchdog_core.sv]
// Per-task check-in watchdog over a table of NUM_SLOTS task slots.
// Input channel (in_valid / in_stall / in_data) carries one operation per
// transaction: scan, register slot, set timeout or check-in. The result
// channel (out_valid / out_stall / out_data) returns one result per input:
// status plus the withheld mask, the bits newly set by a scan and an any flag.
// Register, set timeout and check-in go from accept to ST_LOAD, where the result
// is loaded once the output register is free, and then back to ST_IDLE.
// A scan walks the slot table through its single read port, one slot per
// cycle, then passes through ST_DRAIN and ST_LOAD before the next accept.
// One item is in flight at a time; a finished result sits in an output
// register, so the next transaction is accepted while the receiver stalls.
// A second result waits in ST_LOAD until the output register frees.
// Reset (synchronous, rst_n low) clears the registered and withheld flags;
// timeouts and check-in times are not cleared and are used only after a
// slot has been registered.
// Depends on mtcw_pkg, mtcw_ctrl and mtcw_dp.
`timescale 1ns / 1ps
`default_nettype none

module multi_task_checkin_watchdog_core import mtcw_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  mtcw_in_t   in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output mtcw_out_t  out_data
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  mtcw_cmd_t         cmd;
  mtcw_stat_t        stat;
  logic [SLOT_W-1:0] rd_addr;

  mtcw_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .stat     (stat)
  );

  mtcw_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for multi_task_checkin_watchdog_core
// predicts each result from its own copy of the slot table; needs mtcw_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;
  import mtcw_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  mtcw_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mtcw_out_t out_data;

  // predicted slot table
  logic             slot_live [SLOTS];
  logic [31:0]      slot_limit [SLOTS];
  logic [31:0]      slot_seen [SLOTS];
  logic [SLOTS-1:0] slot_overdue;

  mtcw_out_t pending_reports[$];
  mtcw_out_t want_report;
  int        error_count = 0;
  int        cycle_count = 0;
  int        idle_pct = 13;
  int        stall_pct = 13;

  multi_task_checkin_watchdog_core #(
    .NUM_SLOTS(SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_limit[i] = '0;
      slot_seen[i] = '0;
    end
    slot_overdue = '0;
  end

  // applies one operation to the predicted table and returns its report
  function automatic mtcw_out_t predict_watchdog(input mtcw_in_t op);
    mtcw_out_t   rep;
    logic [31:0] silence;
    rep = '0;
    if (op.mode == MODE_SCAN) begin
      for (int i = 0; i < SLOTS; i++) begin
        silence = op.now_ms - slot_seen[i];
        if (slot_live[i] && !slot_overdue[i] && silence > slot_limit[i]) begin
          slot_overdue[i] = 1'b1;
          rep.newly_withheld[i] = 1'b1;
        end
      end
    end else if (op.task_index >= SLOTS) begin
      rep.status = 1'b1;
    end else if (op.mode == MODE_REGISTER) begin
      slot_live[op.task_index] = 1'b1;
      slot_limit[op.task_index] = op.timeout_value;
      slot_seen[op.task_index] = op.now_ms;
      slot_overdue[op.task_index] = 1'b0;
    end else if (!slot_live[op.task_index]) begin
      rep.status = 1'b1;
    end else if (op.mode == MODE_SET_TIMEOUT) begin
      slot_limit[op.task_index] = op.timeout_value;
    end else begin
      slot_seen[op.task_index] = op.now_ms;
      slot_overdue[op.task_index] = 1'b0;
    end
    rep.withheld_mask = slot_overdue[MASK_W-1:0];
    rep.any_withheld = |slot_overdue;
    return rep;
  endfunction

  // drives one transaction and records its predicted report once accepted
  task automatic send_item(input logic [1:0] mode, input logic [3:0] idx,
                           input logic [31:0] now, input logic [31:0] tmo);
    mtcw_in_t op;
    op.mode = mode;
    op.task_index = idx;
    op.now_ms = now;
    op.timeout_value = tmo;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(predict_watchdog(op));
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_unregistered_slots();
    send_item(MODE_SCAN, 4'd0, 32'd0, 32'd0);
    send_item(MODE_SET_TIMEOUT, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(MODE_CHECKIN, 4'd15, 32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_timeout_edges();
    send_item(MODE_REGISTER, 4'd0, 32'd0, 32'd0);
    send_item(MODE_SCAN, 4'd9, 32'd0, 32'hFFFF_FFFF);
    // silence must be strictly greater than the timeout
    send_item(MODE_SCAN, 4'd0, 32'd1, 32'd0);
    send_item(MODE_SCAN, 4'd0, 32'd2, 32'd0);
    send_item(MODE_CHECKIN, 4'd0, 32'd5, 32'd0);
    send_item(MODE_REGISTER, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_REGISTER, 4'd3, 32'hFFFF_FFF8, 32'd10);
    // time wraps past zero
    send_item(MODE_SCAN, 4'd0, 32'd2, 32'd0);
    send_item(MODE_SCAN, 4'd0, 32'd3, 32'd0);
    send_item(MODE_SET_TIMEOUT, 4'd3, 32'hFFFF_FFFF, 32'd100);
    send_item(MODE_CHECKIN, 4'd3, 32'd3, 32'hFFFF_FFFF);
    send_item(MODE_SCAN, 4'd0, 32'h7FFF_FFFF, 32'd0);
    // register over a live withheld slot
    send_item(MODE_REGISTER, 4'd3, 32'd0, 32'd0);
    send_item(MODE_SET_TIMEOUT, 4'd15, 32'd0, 32'd0);
    send_item(MODE_SCAN, 4'd15, 32'd0, 32'd0);
    send_item(MODE_CHECKIN, 4'd15, 32'd1, 32'hA5A5_5A5A);
  endtask

  task automatic test_drain_pause();
    send_item(MODE_SCAN, 4'd0, 32'd100, 32'd0);
    send_item(MODE_CHECKIN, 4'd0, 32'd100, 32'd0);
    wait_for_reports();
    send_item(MODE_SCAN, 4'd0, 32'd200, 32'd0);
  endtask

  task automatic test_random_traffic(input int count);
    logic [31:0] clock_ms;
    logic [31:0] tmo;
    int          pick;
    // start near the wrap point so it is crossed mid-run
    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    for (int n = 0; n < count; n++) begin
      if (n == 500) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      if (n == 700) begin
        idle_pct = 13;
        stall_pct = 13;
      end
      if (n == 900) wait_for_reports();
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise with unrelated times
        send_item(2'($urandom_range(3)), 4'($urandom_range(15)), $urandom, $urandom);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 60);
        tmo = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 400);
        pick = $urandom_range(99);
        if (pick < 35)
          send_item(MODE_SCAN, 4'($urandom_range(15)), clock_ms, $urandom);
        else if (pick < 50)
          send_item(MODE_REGISTER, 4'($urandom_range(15)), clock_ms, tmo);
        else if (pick < 60)
          send_item(MODE_SET_TIMEOUT, 4'($urandom_range(15)), clock_ms, tmo);
        else
          send_item(MODE_CHECKIN, 4'($urandom_range(15)), clock_ms, tmo);
      end
    end
  endtask

  // receiver: stall at random and check every accepted transaction
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result with no expectation waiting: %h", out_data);
        error_count++;
      end else begin
        want_report = pending_reports.pop_front();
        if (out_data.status !== want_report.status) begin
          $error("status: expected %h, got %h", want_report.status, out_data.status);
          error_count++;
        end
        if (out_data.withheld_mask !== want_report.withheld_mask) begin
          $error("withheld_mask: expected %h, got %h",
                 want_report.withheld_mask, out_data.withheld_mask);
          error_count++;
        end
        if (out_data.newly_withheld !== want_report.newly_withheld) begin
          $error("newly_withheld: expected %h, got %h",
                 want_report.newly_withheld, out_data.newly_withheld);
          error_count++;
        end
        if (out_data.any_withheld !== want_report.any_withheld) begin
          $error("any_withheld: expected %h, got %h",
                 want_report.any_withheld, out_data.any_withheld);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unregistered_slots();
    test_timeout_edges();
    test_drain_pause();
    test_random_traffic(1200);
    wait_for_reports();
    repeat (SLOTS + 8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/mtcw_pkg.sv
rtl/mtcw_ctrl.sv
rtl/mtcw_dp.sv
rtl/multi_task_checkin_watchdog_core.sv
verif/tb_top.sv
